/* rtl/tlrq_pkg.sv */
// shared types, constants and helpers for the timestamp log range query block
// no dependencies; used by tlrq_ctrl, tlrq_dpath and timestamp_log_range_query
`default_nettype none

package tlrq_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W  = 31;
  localparam int ID_W   = 16;
  localparam int GRAN_W = 3;
  localparam int STAT_W = 2;

  // s_axis_tdata layout
  localparam int IN_ID_LSB    = 0;
  localparam int IN_FIRST_LSB = IN_ID_LSB + ID_W;
  localparam int IN_LAST_LSB  = IN_FIRST_LSB + KEY_W;
  localparam int IN_GRAN_LSB  = IN_LAST_LSB + KEY_W;
  localparam int IN_BITS      = IN_GRAN_LSB + GRAN_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // m_axis_tdata layout
  localparam int OUT_BITS   = ID_W + STAT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // result status codes
  localparam logic [STAT_W-1:0] ST_MATCH   = 2'd0;
  localparam logic [STAT_W-1:0] ST_STORED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

  // granularity codes
  localparam logic [GRAN_W-1:0] GR_YEAR   = 3'd0;
  localparam logic [GRAN_W-1:0] GR_MONTH  = 3'd1;
  localparam logic [GRAN_W-1:0] GR_DAY    = 3'd2;
  localparam logic [GRAN_W-1:0] GR_HOUR   = 3'd3;
  localparam logic [GRAN_W-1:0] GR_MINUTE = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_PUT_SCAN = 5'b00010,
    S_PUT_LAST = 5'b00100,
    S_GET_SCAN = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;     // item accepted this cycle
    logic put_scan;  // walk the table downward, shifting larger keys up
    logic put_last;  // write the new entry at the bottom slot
    logic get_scan;  // walk the table upward, emitting matches
    logic finish;    // load the final result of the item
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic put_hit;     // insert slot found above a smaller or equal key
    logic put_bottom;  // every stored key is larger, insert at slot zero
    logic scan_end;    // no read left to issue and none in flight
    logic out_free;    // output register can take a result this cycle
  } sts_t;

  // kept key bits for a granularity; codes above second keep everything
  function automatic logic [KEY_W-1:0] gran_mask(input logic [GRAN_W-1:0] gran);
    logic [KEY_W-1:0] m;
    unique case (gran)
      GR_YEAR:   m = 31'h7C000000;
      GR_MONTH:  m = 31'h7FC00000;
      GR_DAY:    m = 31'h7FFE0000;
      GR_HOUR:   m = 31'h7FFFF000;
      GR_MINUTE: m = 31'h7FFFFFC0;
      default:   m = 31'h7FFFFFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/tlrq_ctrl.sv */
// controller state machine: sequences put and retrieve scans
// depends on tlrq_pkg
`default_nettype none

module tlrq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_action,
  output logic               in_ready,
  input  wire tlrq_pkg::sts_t sts,
  output tlrq_pkg::cmd_t     cmd
);

  tlrq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlrq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlrq_pkg::S_IDLE: begin
        if (in_valid) begin
          priority if (in_action)  state_next = tlrq_pkg::S_GET_SCAN;
          else if (sts.full)       state_next = tlrq_pkg::S_FINISH;
          else if (sts.empty)      state_next = tlrq_pkg::S_PUT_LAST;
          else                     state_next = tlrq_pkg::S_PUT_SCAN;
        end
      end
      tlrq_pkg::S_PUT_SCAN: begin
        priority if (sts.put_hit)   state_next = tlrq_pkg::S_FINISH;
        else if (sts.put_bottom)    state_next = tlrq_pkg::S_PUT_LAST;
        else                        state_next = tlrq_pkg::S_PUT_SCAN;
      end
      tlrq_pkg::S_PUT_LAST: begin
        state_next = tlrq_pkg::S_FINISH;
      end
      tlrq_pkg::S_GET_SCAN: begin
        if (sts.scan_end) state_next = tlrq_pkg::S_FINISH;
      end
      tlrq_pkg::S_FINISH: begin
        if (sts.out_free) state_next = tlrq_pkg::S_IDLE;
      end
      default: state_next = tlrq_pkg::S_IDLE;
    endcase
  end

  assign in_ready     = (state == tlrq_pkg::S_IDLE);
  assign cmd.start    = in_ready && in_valid;
  assign cmd.put_scan = (state == tlrq_pkg::S_PUT_SCAN);
  assign cmd.put_last = (state == tlrq_pkg::S_PUT_LAST);
  assign cmd.get_scan = (state == tlrq_pkg::S_GET_SCAN);
  assign cmd.finish   = (state == tlrq_pkg::S_FINISH) && sts.out_free;

endmodule

`default_nettype wire

/* rtl/tlrq_dpath.sv */
// datapath: sorted entry memory, scan pointers, range compare, pending
// match and output register; depends on tlrq_pkg
`default_nettype none

module tlrq_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tlrq_pkg::cmd_t              cmd,
  output tlrq_pkg::sts_t                   sts,
  input  wire logic                        in_action,
  input  wire logic [tlrq_pkg::ID_W-1:0]   in_id,
  input  wire logic [tlrq_pkg::KEY_W-1:0]  in_first,
  input  wire logic [tlrq_pkg::KEY_W-1:0]  in_last,
  input  wire logic [tlrq_pkg::GRAN_W-1:0] in_gran,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tlrq_pkg::ID_W-1:0]        out_id,
  output logic [tlrq_pkg::STAT_W-1:0]      out_status,
  output logic                             out_last
);

  localparam int AW    = tlrq_pkg::ADDR_W;
  localparam int CW    = tlrq_pkg::CNT_W;
  localparam int KW    = tlrq_pkg::KEY_W;
  localparam int IW    = tlrq_pkg::ID_W;
  localparam int MEM_W = KW + IW;

  // entries stored as {key, id}
  logic [MEM_W-1:0] mem [tlrq_pkg::TABLE_DEPTH];

  logic [CW-1:0] count;
  logic [CW-1:0] rem;
  logic [AW-1:0] addr;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [KW-1:0] rd_key;
  logic [IW-1:0] rd_id;

  logic          op_action;
  logic [KW-1:0] op_key;
  logic [KW-1:0] op_hi;
  logic [KW-1:0] op_mask;
  logic [IW-1:0] op_id;
  logic          op_full;

  logic          pend_vld;
  logic [IW-1:0] pend_id;

  logic          out_free;
  logic          greater;
  logic [KW-1:0] masked;
  logic          in_range;
  logic          stall;
  logic          issue;
  logic          put_hit;
  logic          put_bottom;
  logic          we;
  logic [AW-1:0] waddr;
  logic [MEM_W-1:0] wdata;
  logic          push;
  logic [KW-1:0] start_mask;

  assign out_free   = !out_valid || out_ready;
  assign greater    = rd_key > op_key;
  assign masked     = rd_key & op_mask;
  assign in_range   = (masked >= op_key) && (masked <= op_hi);
  assign put_hit    = rd_vld && !greater;
  assign put_bottom = rd_vld && greater && (rd_idx == '0);
  // a match that would displace the pending one waits for the output
  assign stall      = cmd.get_scan && rd_vld && in_range && pend_vld && !out_free;
  assign push       = cmd.get_scan && rd_vld && in_range && pend_vld && out_free;
  assign issue      = (rem != '0) &&
                      ((cmd.put_scan && !put_hit) || (cmd.get_scan && !stall));
  assign start_mask = tlrq_pkg::gran_mask(in_gran);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = {op_key, op_id};
    if (cmd.put_scan && rd_vld) begin
      we    = 1'b1;
      waddr = rd_idx + AW'(1);
      wdata = greater ? {rd_key, rd_id} : {op_key, op_id};
    end else if (cmd.put_last) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (issue) begin
      {rd_key, rd_id} <= mem[addr];
      rd_idx          <= addr;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rem    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.start) begin
        rem <= (!in_action && count == CW'(tlrq_pkg::TABLE_DEPTH)) ? '0 : count;
      end else if (issue) begin
        rem <= rem - CW'(1);
      end
      rd_vld <= issue || stall;
      if ((cmd.put_scan && put_hit) || cmd.put_last) count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr <= in_action ? '0 : AW'(count - CW'(1));
    end else if (issue) begin
      addr <= op_action ? addr + AW'(1) : addr - AW'(1);
    end
  end

  // operands of the item in progress
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_action <= in_action;
      op_id     <= in_id;
      op_full   <= (count == CW'(tlrq_pkg::TABLE_DEPTH));
      op_mask   <= start_mask;
      op_key    <= in_action ? (in_first & start_mask) : in_first;
      op_hi     <= in_last & start_mask;
    end
  end

  // one match held back so the final one can carry the last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (cmd.start || cmd.finish) begin
      pend_vld <= 1'b0;
    end else if (cmd.get_scan && rd_vld && in_range && !stall) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.get_scan && rd_vld && in_range && !stall) pend_id <= rd_id;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_id     <= pend_id;
      out_status <= tlrq_pkg::ST_MATCH;
      out_last   <= 1'b0;
    end else if (cmd.finish) begin
      out_last <= 1'b1;
      priority if (!op_action) begin
        out_id     <= '0;
        out_status <= op_full ? tlrq_pkg::ST_DROPPED : tlrq_pkg::ST_STORED;
      end else if (pend_vld) begin
        out_id     <= pend_id;
        out_status <= tlrq_pkg::ST_MATCH;
      end else begin
        out_id     <= '0;
        out_status <= tlrq_pkg::ST_NOMATCH;
      end
    end
  end

  assign sts.full       = (count == CW'(tlrq_pkg::TABLE_DEPTH));
  assign sts.empty      = (count == '0);
  assign sts.put_hit    = put_hit;
  assign sts.put_bottom = put_bottom;
  assign sts.scan_end   = (rem == '0) && !rd_vld;
  assign sts.out_free   = out_free;

endmodule

`default_nettype wire

/* rtl/timestamp_log_range_query.sv */
// top level of the timestamp log range query block: stream ports,
// controller and datapath; depends on tlrq_pkg, tlrq_ctrl, tlrq_dpath
`default_nettype none

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: log_id, first_stamp,
//                                               last_stamp, granularity;
//                                               tuser: action
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result_id, status;
//                                               tlast: last_of_run
//
// from an accepted item to its final result: a put reads the table from the top down,
// shifting larger keys up by one; a retrieve makes one read per entry and can be
// held up by output stalls
// a put into a full table goes straight to its result, loaded once the output is free
// reset clears the controller state, entry count and valid flags but not the table;
// a new item is taken once the previous one has loaded its final result

module timestamp_log_range_query (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // log_id [15:0], first_stamp [46:16], last_stamp [77:47],
  // granularity [80:78], zero fill above
  input  wire logic [tlrq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action [0]
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // result_id [15:0], status [17:16], zero fill above
  output logic [tlrq_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast
);

  tlrq_pkg::cmd_t cmd;
  tlrq_pkg::sts_t sts;

  logic [tlrq_pkg::ID_W-1:0]   out_id;
  logic [tlrq_pkg::STAT_W-1:0] out_status;

  // unpack the input item
  logic [tlrq_pkg::ID_W-1:0]   in_id;
  logic [tlrq_pkg::KEY_W-1:0]  in_first;
  logic [tlrq_pkg::KEY_W-1:0]  in_last;
  logic [tlrq_pkg::GRAN_W-1:0] in_gran;

  assign in_id    = s_axis_tdata[tlrq_pkg::IN_ID_LSB +: tlrq_pkg::ID_W];
  assign in_first = s_axis_tdata[tlrq_pkg::IN_FIRST_LSB +: tlrq_pkg::KEY_W];
  assign in_last  = s_axis_tdata[tlrq_pkg::IN_LAST_LSB +: tlrq_pkg::KEY_W];
  assign in_gran  = s_axis_tdata[tlrq_pkg::IN_GRAN_LSB +: tlrq_pkg::GRAN_W];

  // sequencing of the scans
  tlrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, compare and result registers
  tlrq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (s_axis_tuser),
    .in_id      (in_id),
    .in_first   (in_first),
    .in_last    (in_last),
    .in_gran    (in_gran),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_id     (out_id),
    .out_status (out_status),
    .out_last   (m_axis_tlast)
  );

  // pack the result item
  assign m_axis_tdata = {{(tlrq_pkg::OUT_DATA_W - tlrq_pkg::OUT_BITS){1'b0}},
                         out_status, out_id};

  // at most one scan or finish command at a time
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.put_scan, cmd.put_last, cmd.get_scan, cmd.finish}))
    else $error("controller issued overlapping commands");

  // only a match can be a non-final result
  a_nonlast_is_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> out_status == tlrq_pkg::ST_MATCH)
    else $error("non-final result with a status other than match");

  // a put into a full table goes straight to its result
  a_full_put_finishes: assert property (@(posedge clk) disable iff (rst)
    cmd.start && !s_axis_tuser && sts.full |=> !cmd.put_scan && !cmd.put_last)
    else $error("put into a full table started a table update");

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for timestamp_log_range_query: stream driver, result monitor
// and a sorted-table predictor built in the testbench; depends on tlrq_pkg and the rtl
`timescale 1ns / 1ps

module tb;

  // action codes carried on s_axis_tuser
  localparam bit ACT_PUT = 1'b0;
  localparam bit ACT_GET = 1'b1;

  localparam int ITEMS_PER_PHASE = 80;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = tlrq_pkg::TABLE_DEPTH + 8;

  typedef struct {
    bit                        action;
    bit [tlrq_pkg::ID_W-1:0]   log_id;
    bit [tlrq_pkg::KEY_W-1:0]  first_stamp;
    bit [tlrq_pkg::KEY_W-1:0]  last_stamp;
    bit [tlrq_pkg::GRAN_W-1:0] granularity;
  } log_req_t;

  typedef struct {
    bit [tlrq_pkg::ID_W-1:0]   result_id;
    bit [tlrq_pkg::STAT_W-1:0] status;
    bit                        last_of_run;
  } log_resp_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tlrq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tlrq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;

  timestamp_log_range_query DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // items waiting to be offered, and results the table should still produce
  log_req_t  log_requests[$];
  log_resp_t due_results[$];

  // shadow copy of the sorted log table
  bit [tlrq_pkg::KEY_W-1:0] shadow_key[tlrq_pkg::TABLE_DEPTH];
  bit [tlrq_pkg::ID_W-1:0]  shadow_id[tlrq_pkg::TABLE_DEPTH];
  int                       shadow_count = 0;

  int queued_total   = 0;
  int accepted_total = 0;
  int errors         = 0;
  int n_puts = 0, n_gets = 0, n_drops = 0, n_empty = 0, n_matches = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;   // bumped by the sequence to ask for a long receiver hold-off
  int hold_seen      = 0;
  int hold_left      = 0;
  logic in_fire      = 1'b0;
  int idle_cycles    = 0;

  // packed key: year offset, month, day, hour, minute, second from the top down
  function automatic bit [tlrq_pkg::KEY_W-1:0] make_stamp(int yr, int mon, int day, int hr,
                                                          int mn, int sec);
    bit [tlrq_pkg::KEY_W-1:0] k;
    k = {yr[4:0], mon[3:0], day[4:0], hr[4:0], mn[5:0], sec[5:0]};
    return k;
  endfunction

  // kept key bits for a granularity: count the fields from the year downward
  function automatic bit [tlrq_pkg::KEY_W-1:0] kept_bits(bit [tlrq_pkg::GRAN_W-1:0] gran);
    int kept;
    bit [tlrq_pkg::KEY_W-1:0] ones;
    ones = '1;
    case (gran)
      tlrq_pkg::GR_YEAR:   kept = 5;
      tlrq_pkg::GR_MONTH:  kept = 9;
      tlrq_pkg::GR_DAY:    kept = 14;
      tlrq_pkg::GR_HOUR:   kept = 19;
      tlrq_pkg::GR_MINUTE: kept = 25;
      default:             kept = tlrq_pkg::KEY_W;   // second, and the two codes above it
    endcase
    return ones << (tlrq_pkg::KEY_W - kept);
  endfunction

  // mostly a small pool of nearby stamps so that keys collide and ranges hit,
  // sometimes a fully random 31-bit key
  function automatic bit [tlrq_pkg::KEY_W-1:0] pick_stamp();
    bit [tlrq_pkg::KEY_W-1:0] k;
    bit [31:0] rnd;
    if ($urandom_range(0, 9) == 0) begin
      rnd = $urandom();
      k = rnd[tlrq_pkg::KEY_W-1:0];
    end else begin
      k = make_stamp($urandom_range(23, 24), $urandom_range(1, 3), $urandom_range(1, 4),
                     $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
    end
    return k;
  endfunction

  // update the shadow table for one accepted item and queue what it should produce
  task automatic log_table_apply(input log_req_t r);
    int pos;
    int i;
    int hits;
    bit [tlrq_pkg::KEY_W-1:0] m;
    bit [tlrq_pkg::KEY_W-1:0] lo;
    bit [tlrq_pkg::KEY_W-1:0] hi;
    bit [tlrq_pkg::KEY_W-1:0] k;
    log_resp_t o;
    if (r.action == ACT_PUT) begin
      n_puts++;
      o.result_id = '0;
      o.last_of_run = 1'b1;
      if (shadow_count >= tlrq_pkg::TABLE_DEPTH) begin
        o.status = tlrq_pkg::ST_DROPPED;
        n_drops++;
      end else begin
        // equal keys stay in insertion order: insert after every key not above it
        pos = shadow_count;
        while (pos > 0 && shadow_key[pos-1] > r.first_stamp) pos--;
        for (i = shadow_count; i > pos; i--) begin
          shadow_key[i] = shadow_key[i-1];
          shadow_id[i]  = shadow_id[i-1];
        end
        shadow_key[pos] = r.first_stamp;
        shadow_id[pos]  = r.log_id;
        shadow_count++;
        o.status = tlrq_pkg::ST_STORED;
      end
      due_results.push_back(o);
    end else begin
      n_gets++;
      m  = kept_bits(r.granularity);
      lo = r.first_stamp & m;
      hi = r.last_stamp & m;
      hits = 0;
      for (i = 0; i < shadow_count; i++) begin
        k = shadow_key[i] & m;
        if (k >= lo && k <= hi) begin
          o.result_id = shadow_id[i];
          o.status = tlrq_pkg::ST_MATCH;
          o.last_of_run = 1'b0;
          due_results.push_back(o);
          hits++;
        end
      end
      if (hits == 0) begin
        o.result_id = '0;
        o.status = tlrq_pkg::ST_NOMATCH;
        o.last_of_run = 1'b1;
        due_results.push_back(o);
        n_empty++;
      end else begin
        due_results[$].last_of_run = 1'b1;
        n_matches += hits;
      end
    end
  endtask

  task automatic queue_item(input bit act, input int id, input bit [tlrq_pkg::KEY_W-1:0] first,
                            input bit [tlrq_pkg::KEY_W-1:0] last, input int gran);
    log_req_t r;
    r.action      = act;
    r.log_id      = id[tlrq_pkg::ID_W-1:0];
    r.first_stamp = first;
    r.last_stamp  = last;
    r.granularity = gran[tlrq_pkg::GRAN_W-1:0];
    log_requests.push_back(r);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || due_results.size() != 0) @(negedge clk);
  endtask

  // driver: a new item goes out when the bus is empty or the last one was taken
  always @(negedge clk) begin : drive_proc
    log_req_t r;
    logic [tlrq_pkg::IN_DATA_W-1:0] d;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (log_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = log_requests.pop_front();
        d = '0;
        d[tlrq_pkg::IN_ID_LSB +: tlrq_pkg::ID_W]      = r.log_id;
        d[tlrq_pkg::IN_FIRST_LSB +: tlrq_pkg::KEY_W]  = r.first_stamp;
        d[tlrq_pkg::IN_LAST_LSB +: tlrq_pkg::KEY_W]   = r.last_stamp;
        d[tlrq_pkg::IN_GRAN_LSB +: tlrq_pkg::GRAN_W]  = r.granularity;
        s_axis_tdata  <= d;
        s_axis_tuser  <= r.action;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request so the block backs up
  always @(negedge clk) begin : recv_proc
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: predict on each accepted item, check each accepted result in order
  always @(posedge clk) begin : check_proc
    log_req_t  r;
    log_resp_t e;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        r.action      = s_axis_tuser;
        r.log_id      = s_axis_tdata[tlrq_pkg::IN_ID_LSB +: tlrq_pkg::ID_W];
        r.first_stamp = s_axis_tdata[tlrq_pkg::IN_FIRST_LSB +: tlrq_pkg::KEY_W];
        r.last_stamp  = s_axis_tdata[tlrq_pkg::IN_LAST_LSB +: tlrq_pkg::KEY_W];
        r.granularity = s_axis_tdata[tlrq_pkg::IN_GRAN_LSB +: tlrq_pkg::GRAN_W];
        log_table_apply(r);
        accepted_total++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result with none outstanding: result_id %0h status %0d last_of_run %0b",
                 m_axis_tdata[tlrq_pkg::ID_W-1:0],
                 m_axis_tdata[tlrq_pkg::ID_W +: tlrq_pkg::STAT_W], m_axis_tlast);
          errors++;
        end else begin
          e = due_results.pop_front();
          if (m_axis_tdata[tlrq_pkg::ID_W-1:0] !== e.result_id) begin
            $error("result_id: expected %0h, got %0h", e.result_id,
                   m_axis_tdata[tlrq_pkg::ID_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[tlrq_pkg::ID_W +: tlrq_pkg::STAT_W] !== e.status) begin
            $error("status: expected %0d, got %0d", e.status,
                   m_axis_tdata[tlrq_pkg::ID_W +: tlrq_pkg::STAT_W]);
            errors++;
          end
          if (m_axis_tlast !== e.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", e.last_of_run, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sequence_proc
    bit [tlrq_pkg::KEY_W-1:0] k_mid;
    bit [tlrq_pkg::KEY_W-1:0] k_sec0;
    bit [tlrq_pkg::KEY_W-1:0] k_sec31;
    bit [tlrq_pkg::KEY_W-1:0] a;
    bit [tlrq_pkg::KEY_W-1:0] b;
    int phase;
    int n;
    int g;
    k_mid   = make_stamp(24, 6, 15, 12, 30, 30);
    k_sec0  = make_stamp(24, 6, 15, 12, 30, 0);
    k_sec31 = make_stamp(24, 6, 15, 12, 30, 31);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, extreme keys and ids, equal keys, odd field values,
    // every granularity, inverted and degenerate ranges
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    queue_item(ACT_GET, 0, '0, '1, 5);
    queue_item(ACT_PUT, 0, '0, '0, 0);
    queue_item(ACT_PUT, 16'hFFFF, '1, '1, 7);
    queue_item(ACT_PUT, 16'h1111, k_mid, '0, 0);
    queue_item(ACT_PUT, 16'h2222, k_mid, '1, 7);   // same key, must follow 1111
    queue_item(ACT_PUT, 16'h3333, k_sec0, '0, 0);
    queue_item(ACT_PUT, 16'h4444, make_stamp(24, 13, 31, 25, 61, 62), '0, 0);
    for (g = 0; g < 8; g++) queue_item(ACT_GET, 0, k_mid, k_mid, g);
    queue_item(ACT_GET, 0, k_sec31, k_mid, int'(tlrq_pkg::GR_MINUTE) + 1);  // start past end
    queue_item(ACT_GET, 0, k_sec31, k_mid, int'(tlrq_pkg::GR_HOUR));        // equal once masked
    queue_item(ACT_GET, 0, '0, '0, 5);
    queue_item(ACT_GET, 0, '1, '1, 6);
    queue_item(ACT_GET, 0, '0, '1, int'(tlrq_pkg::GR_YEAR));
    wait_drained();

    // random phases: none idle (with the long receiver hold-off), sender idle,
    // receiver stalling, both lightly
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req++; end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        a = pick_stamp();
        b = pick_stamp();
        if ($urandom_range(0, 99) < 45)
          queue_item(ACT_PUT, $urandom_range(0, 65535), a, b, $urandom_range(0, 7));
        else
          queue_item(ACT_GET, $urandom_range(0, 65535), a, b, $urandom_range(0, 7));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_results.size() != 0)
      $error("%0d results never arrived", due_results.size());
    $display("ran %0d items: %0d puts (%0d dropped on a full table), %0d retrieves",
             accepted_total, n_puts, n_drops, n_gets);
    $display("retrieves gave %0d matches and %0d empty results; table holds %0d",
             n_matches, n_empty, shadow_count);
    if (errors == 0 && due_results.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
